@@ design/mmlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_pkg: shared types and constants of the line code encoder
// Mode codes, the two-bit line level encoding and the symbol burst that
// the classifier hands to the symbol emitter.
// ----------------------------------------------------------------------------
package mmlc_pkg;

  // Longest burst one data bit can cause (the B8ZS substitution).
  localparam int unsigned MaxSym = 8;
  localparam int unsigned SymIdxW = $clog2(MaxSym);
  // Default depth of the burst queue between classifier and emitter.
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [2:0] {
    MODE_NRZL   = 3'd0,
    MODE_NRZI   = 3'd1,
    MODE_MANCH  = 3'd2,
    MODE_DMANCH = 3'd3,
    MODE_AMI    = 3'd4,
    MODE_B8ZS   = 3'd5,
    MODE_HDB3   = 3'd6
  } mode_e;

  typedef logic signed [1:0] level_t;

  localparam level_t LvZero = 2'sb00;
  localparam level_t LvPos  = 2'sb01;
  localparam level_t LvNeg  = 2'sb11;

  // One burst of symbols; entries 0 to last are sent in order.
  typedef struct packed {
    level_t [MaxSym-1:0] lv;
    logic [SymIdxW-1:0]  last;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic level_t pol(input logic neg);
    return neg ? LvNeg : LvPos;
  endfunction

endpackage
`default_nettype wire

@@ design/mmlc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_in_if: data bit channel
// Valid/ready channel carrying one data bit and the end-of-stream flag.
// ----------------------------------------------------------------------------
interface mmlc_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic final_bit;

  modport source (output valid, output data_bit, output final_bit, input ready);
  modport sink   (input valid, input data_bit, input final_bit, output ready);
endinterface
`default_nettype wire

@@ design/mmlc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_out_if: line symbol channel
// Valid/ready channel carrying one line symbol and its end-of-run flag.
// ----------------------------------------------------------------------------
interface mmlc_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] level;
  logic              run_end;

  modport source (output valid, output level, output run_end, input ready);
  modport sink   (input valid, input level, input run_end, output ready);
endinterface
`default_nettype wire

@@ design/mmlc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_front: bit classifier
// Holds the mode register and the coder state, and turns each accepted
// data bit into a burst of zero to eight symbols for the queue.
// ----------------------------------------------------------------------------
module mmlc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_wdata_i,
  mmlc_in_if.sink               in_i,
  input  wire mmlc_pkg::q_stat_t q_stat_i,
  output mmlc_pkg::burst_t      burst_o,
  output logic                  push_o
);

  mmlc_pkg::mode_e mode_q;
  logic [2:0] held_q, held_d;
  logic lm_neg_q, lm_neg_d;
  logic odd_q, odd_d;
  logic nrzi_q, nrzi_d;
  logic half_q, half_d;
  logic first_neg;
  logic emit;
  logic accept;
  mmlc_pkg::burst_t burst;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    held_d    = held_q;
    lm_neg_d  = lm_neg_q;
    odd_d     = odd_q;
    nrzi_d    = nrzi_q;
    half_d    = half_q;
    burst     = '0;
    emit      = 1'b0;
    first_neg = half_q ^ in_i.data_bit;
    unique case (mode_q)
      mmlc_pkg::MODE_NRZL: begin
        burst.lv[0] = mmlc_pkg::pol(in_i.data_bit);
        emit = 1'b1;
      end
      mmlc_pkg::MODE_NRZI: begin
        nrzi_d = nrzi_q ^ in_i.data_bit;
        burst.lv[0] = mmlc_pkg::pol(nrzi_d);
        emit = 1'b1;
      end
      mmlc_pkg::MODE_MANCH: begin
        burst.lv[0] = mmlc_pkg::pol(in_i.data_bit);
        burst.lv[1] = mmlc_pkg::pol(!in_i.data_bit);
        burst.last  = mmlc_pkg::SymIdxW'(1);
        emit = 1'b1;
      end
      mmlc_pkg::MODE_DMANCH: begin
        burst.lv[0] = mmlc_pkg::pol(first_neg);
        burst.lv[1] = mmlc_pkg::pol(!first_neg);
        burst.last  = mmlc_pkg::SymIdxW'(1);
        half_d = !first_neg;
        emit = 1'b1;
      end
      mmlc_pkg::MODE_AMI: begin
        if (in_i.data_bit) begin
          lm_neg_d = !lm_neg_q;
          burst.lv[0] = mmlc_pkg::pol(!lm_neg_q);
        end
        emit = 1'b1;
      end
      mmlc_pkg::MODE_B8ZS: begin
        if (in_i.data_bit) begin
          // Held zeros first, then the mark.
          burst.lv[held_q] = mmlc_pkg::pol(!lm_neg_q);
          burst.last = held_q;
          lm_neg_d = !lm_neg_q;
          held_d = '0;
          emit = 1'b1;
        end else if (held_q == 3'd7) begin
          // 000VB0VB, polarity ends where it began.
          burst.lv[3] = mmlc_pkg::pol(lm_neg_q);
          burst.lv[4] = mmlc_pkg::pol(!lm_neg_q);
          burst.lv[6] = mmlc_pkg::pol(!lm_neg_q);
          burst.lv[7] = mmlc_pkg::pol(lm_neg_q);
          burst.last  = mmlc_pkg::SymIdxW'(7);
          held_d = '0;
          emit = 1'b1;
        end else if (in_i.final_bit) begin
          burst.last = held_q;
          held_d = '0;
          emit = 1'b1;
        end else begin
          held_d = held_q + 3'd1;
        end
      end
      mmlc_pkg::MODE_HDB3: begin
        if (in_i.data_bit) begin
          burst.lv[held_q] = mmlc_pkg::pol(!lm_neg_q);
          burst.last = held_q;
          lm_neg_d = !lm_neg_q;
          odd_d = !odd_q;
          held_d = '0;
          emit = 1'b1;
        end else if (held_q >= 3'd3) begin
          if (odd_q) begin
            // 000V
            burst.lv[3] = mmlc_pkg::pol(lm_neg_q);
          end else begin
            // B00V
            burst.lv[0] = mmlc_pkg::pol(!lm_neg_q);
            burst.lv[3] = mmlc_pkg::pol(!lm_neg_q);
            lm_neg_d = !lm_neg_q;
          end
          burst.last = mmlc_pkg::SymIdxW'(3);
          odd_d  = 1'b0;
          held_d = '0;
          emit = 1'b1;
        end else if (in_i.final_bit) begin
          burst.last = held_q;
          held_d = '0;
          emit = 1'b1;
        end else begin
          held_d = held_q + 3'd1;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase
  end

  assign burst_o = burst;
  assign push_o  = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mmlc_pkg::MODE_NRZL;
      held_q   <= '0;
      lm_neg_q <= 1'b1;
      odd_q    <= 1'b0;
      nrzi_q   <= 1'b0;
      half_q   <= 1'b1;
    end else if (cfg_we_i) begin
      // Mode change drops any held zeros.
      mode_q <= mmlc_pkg::mode_e'(cfg_wdata_i);
      held_q <= '0;
    end else if (accept) begin
      held_q   <= held_d;
      lm_neg_q <= lm_neg_d;
      odd_q    <= odd_d;
      nrzi_q   <= nrzi_d;
      half_q   <= half_d;
    end
  end

`ifndef SYNTHESIS
  a_hdb3_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mmlc_pkg::MODE_HDB3) |-> (held_q <= 3'd3))
    else $error("HDB3 holds more than three zeros");
  a_ami_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && in_i.data_bit && mode_q == mmlc_pkg::MODE_AMI)
      |=> (lm_neg_q != $past(lm_neg_q)))
    else $error("AMI mark did not alternate polarity");
`endif

endmodule
`default_nettype wire

@@ design/mmlc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_fifo: burst queue
// Short first-in first-out queue of symbol bursts between classifier
// and emitter.
// ----------------------------------------------------------------------------
module mmlc_fifo #(
  parameter int unsigned Depth = mmlc_pkg::QueueDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mmlc_pkg::burst_t  wdata_i,
  input  wire logic              pop_i,
  output mmlc_pkg::burst_t       rdata_o,
  output mmlc_pkg::q_stat_t      stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mmlc_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("burst queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("burst queue underflow");
`endif

endmodule
`default_nettype wire

@@ design/mmlc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmlc_back: symbol emitter
// Walks the head burst into the output register, one symbol per ready cycle.
// ----------------------------------------------------------------------------
module mmlc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mmlc_pkg::burst_t  head_i,
  input  wire mmlc_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  mmlc_out_if.source             out_o
);

  logic [mmlc_pkg::SymIdxW-1:0] idx_q;
  logic out_valid_q;
  mmlc_pkg::level_t level_q;
  logic run_end_q;
  logic load;
  logic take;
  logic at_last;

  assign load    = !out_valid_q || out_o.ready;
  assign take    = load && !q_stat_i.empty;
  assign at_last = (idx_q == head_i.last);
  assign pop_o   = take && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= !q_stat_i.empty;
      end
      if (take) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q   <= head_i.lv[idx_q];
      run_end_q <= at_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.level   = level_q;
  assign out_o.run_end = run_end_q;

`ifndef SYNTHESIS
  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty |-> (idx_q <= head_i.last))
    else $error("symbol index past end of burst");
`endif

endmodule
`default_nettype wire

@@ design/multi_mode_line_code_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_mode_line_code_encoder: NRZ/Manchester/AMI/B8ZS/HDB3 line encoder
// Data bits in, ternary line symbols out, scheme chosen by a mode register.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one data bit per item plus final_bit, which flushes
//          zeros held for B8ZS or HDB3 as plain zero symbols.
//   out_o  carries one line symbol per item (+1, 0, -1 as a signed 2-bit
//          level); run_end marks the last symbol caused by one data bit.
//   cfg_we_i/cfg_wdata_i write the mode (0 NRZ-L ... 6 HDB3, 7 zeros only);
//          write only while idle. A write drops any held zeros.
// Flow: a taken bit's burst goes into the queue, then its first symbol into
//   the output register. The emitter sends one symbol per cycle while
//   out_o.ready allows. A bit makes 1 symbol for NRZ and AMI, 2 for both
//   Manchester modes, up to 8 for a B8ZS substitution burst. Held zeros
//   make none until flushed. The classifier runs ahead by QueueDepth bursts.
// Reset: mode NRZ-L, no held zeros, last mark negative (first mark +1),
//   NRZ-I level +1, differential Manchester previous half -1, queue empty.
// Stall: a low out_o.ready holds the output symbol; the queue fills and
//   then in_i.ready drops until the emitter drains a burst.
// ----------------------------------------------------------------------------
module multi_mode_line_code_encoder #(
  parameter int unsigned QueueDepth = mmlc_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  mmlc_in_if.sink         in_i,
  mmlc_out_if.source      out_o
);

  // Bursts travel from classifier to emitter through the queue.
  mmlc_pkg::burst_t  push_burst;
  mmlc_pkg::burst_t  head_burst;
  mmlc_pkg::q_stat_t q_stat;
  logic push;
  logic pop;

  // Classify each bit and update the coder state.
  mmlc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .burst_o     (push_burst),
    .push_o      (push)
  );

  // Hold pending bursts so each side can stall on its own.
  mmlc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_burst),
    .pop_i   (pop),
    .rdata_o (head_burst),
    .stat_o  (q_stat)
  );

  // Serialize bursts into symbols behind the output register.
  mmlc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_burst),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire
